FILE: rtl/slb_pkg.sv
// Shared types, constants and fixed-point helpers for the soft-light layer blend.
// Used by the RTL, the checker and tb_top; depends on nothing else.
package slb_pkg;

    localparam int CHANNEL_BITS = 16;
    localparam int FIELD_W      = 16;
    localparam int CFG_IDX_W    = 4;
    localparam int NCH          = 3;

    localparam int CW = CHANNEL_BITS;
    localparam int PW = 2 * CW;
    localparam int RW = 2 * CW + 2;
    localparam int ZW = RW + 1;
    localparam int QW = CW + 1;
    localparam int DW = CW + 1;
    localparam int PRE_STAGES = 8;
    localparam int NV = PRE_STAGES + QW;

    localparam logic [CW-1:0] FULL = {CW{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_OPACITY     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MASK_ENABLE = CFG_IDX_W'(1);

    typedef logic [CW-1:0] chan_t;
    typedef logic [NCH-1:0][CW-1:0] lanes_t;

    typedef struct packed {
        lanes_t         base;
        logic [NCH-1:0] neg;
        logic           pass;
        chan_t          alpha;
        logic           run_end;
    } side_t;

    typedef struct packed {
        logic [FIELD_W-1:0] red;
        logic [FIELD_W-1:0] green;
        logic [FIELD_W-1:0] blue;
        logic [FIELD_W-1:0] alpha;
        logic               run_end;
    } out_item_t;

    function automatic chan_t clamp_chan(input logic [FIELD_W-1:0] v);
        if (v > FIELD_W'(FULL)) begin
            return FULL;
        end
        return v[CW-1:0];
    endfunction

    // x / FULL rounded to nearest, by reciprocal estimate and remainder correction
    function automatic chan_t rnd_full(input logic [RW-1:0] x);
        logic [ZW-1:0] z;
        logic [ZW-1:0] q1;
        logic [ZW-1:0] fz;
        logic [ZW-1:0] r;
        logic [ZW-1:0] f1;
        logic [ZW-1:0] f2;
        logic [ZW-1:0] qf;
        f1 = ZW'(FULL);
        f2 = f1 << 1;
        z  = ZW'(x) + ZW'(FULL >> 1);
        q1 = (z + (z >> CW)) >> CW;
        fz = (q1 << CW) - q1;
        r  = z - fz;
        if (r >= f2) begin
            qf = q1 + ZW'(2);
        end else if (r >= f1) begin
            qf = q1 + ZW'(1);
        end else begin
            qf = q1;
        end
        return qf[CW-1:0];
    endfunction

endpackage

FILE: rtl/soft_light_layer_blend.sv
// Soft-light layer blend: eight arithmetic stages, a 17-stage divider per colour
// channel and a two-entry output skid buffer. Depends on slb_pkg and slb_div.
// Throughput: one item per cycle unless a full, unread output buffer stalls the pipeline;
// the divider's one-bit-per-stage pipeline sets the depth.
// Reset (aresetn low, synchronous): pipeline and buffer empty, opacity full, mask off.
module soft_light_layer_blend import slb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [FIELD_W-1:0]   s_base_red,
    input  logic [FIELD_W-1:0]   s_base_green,
    input  logic [FIELD_W-1:0]   s_base_blue,
    input  logic [FIELD_W-1:0]   s_base_alpha,
    input  logic [FIELD_W-1:0]   s_top_red,
    input  logic [FIELD_W-1:0]   s_top_green,
    input  logic [FIELD_W-1:0]   s_top_blue,
    input  logic [FIELD_W-1:0]   s_top_alpha,
    input  logic [FIELD_W-1:0]   s_mask_value,
    input  logic                 s_run_end,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [FIELD_W-1:0]   m_result_red,
    output logic [FIELD_W-1:0]   m_result_green,
    output logic [FIELD_W-1:0]   m_result_blue,
    output logic [FIELD_W-1:0]   m_result_alpha,
    output logic                 m_result_run_end
);

    chan_t          opacity_reg;
    logic           mask_en_reg;
    logic [NV-1:0]  v_reg;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    out_item_t      fifo_reg [2];
    logic           adv;
    logic           push;
    logic           pop;

    lanes_t         in_base;
    lanes_t         in_top;
    chan_t          in_ba;
    chan_t          in_ta;
    chan_t          in_min;

    lanes_t                   s1_base_reg;
    chan_t                    s1_ba_reg;
    chan_t                    s1_mk_reg;
    logic                     s1_re_reg;
    logic [PW-1:0]            s1_pca_reg;
    logic [NCH-1:0][PW-1:0]   s1_pil_reg;
    logic [NCH-1:0][PW-1:0]   s1_pnil_reg;

    lanes_t                   s2_base_reg;
    chan_t                    s2_ba_reg;
    chan_t                    s2_mk_reg;
    logic                     s2_re_reg;
    chan_t                    s2_ca0_reg;
    lanes_t                   s2_mul_reg;
    lanes_t                   s2_scr_reg;

    lanes_t                   s3_base_reg;
    chan_t                    s3_ba_reg;
    logic                     s3_re_reg;
    chan_t                    s3_ca0_reg;
    logic [PW-1:0]            s3_pmk_reg;
    logic [NCH-1:0][PW-1:0]   s3_pa_reg;
    logic [NCH-1:0][PW-1:0]   s3_pb_reg;

    lanes_t                   s4_base_reg;
    chan_t                    s4_ba_reg;
    logic                     s4_re_reg;
    chan_t                    s4_ca_reg;
    lanes_t                   s4_comp_reg;

    lanes_t                   s5_base_reg;
    chan_t                    s5_ba_reg;
    logic                     s5_re_reg;
    chan_t                    s5_ca_reg;
    lanes_t                   s5_comp_reg;
    logic [PW-1:0]            s5_pna_reg;

    lanes_t                   s6_base_reg;
    chan_t                    s6_ba_reg;
    logic                     s6_re_reg;
    chan_t                    s6_ca_reg;
    chan_t                    s6_na_reg;
    logic [NCH-1:0]           s6_neg_reg;
    lanes_t                   s6_mag_reg;

    lanes_t                   s7_base_reg;
    chan_t                    s7_ba_reg;
    logic                     s7_re_reg;
    chan_t                    s7_na_reg;
    logic [NCH-1:0]           s7_neg_reg;
    logic                     s7_pass_reg;
    logic [NCH-1:0][PW-1:0]   s7_pmc_reg;

    logic [NCH-1:0][RW-1:0]   num_reg;
    logic [DW-1:0]            den_reg;
    side_t                    s8_side_reg;
    side_t                    side_reg [QW];

    logic [NCH-1:0][QW-1:0]   quo;
    lanes_t                   res;
    logic [CW+1:0]            sum_w [NCH];
    out_item_t                item;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opacity_reg <= FULL;
            mask_en_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_OPACITY: begin
                    opacity_reg <= clamp_chan(cfg_data);
                end
                REG_MASK_ENABLE: begin
                    mask_en_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // flow control: advance unless the last stage would push into a full buffer
    assign pop     = m_valid && m_ready;
    assign adv     = !(cnt_reg == 2'd2 && v_reg[NV-1] && !pop);
    assign push    = adv && v_reg[NV-1];
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NV-2:0], s_valid};
        end
    end

    // stage 1: saturate and form first products
    always_comb begin
        in_base[0] = clamp_chan(s_base_red);
        in_base[1] = clamp_chan(s_base_green);
        in_base[2] = clamp_chan(s_base_blue);
        in_top[0]  = clamp_chan(s_top_red);
        in_top[1]  = clamp_chan(s_top_green);
        in_top[2]  = clamp_chan(s_top_blue);
        in_ba      = clamp_chan(s_base_alpha);
        in_ta      = clamp_chan(s_top_alpha);
        in_min     = (in_ba < in_ta) ? in_ba : in_ta;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_base_reg <= in_base;
            s1_ba_reg   <= in_ba;
            s1_mk_reg   <= clamp_chan(s_mask_value);
            s1_re_reg   <= s_run_end;
            s1_pca_reg  <= PW'(in_min) * PW'(opacity_reg);
            for (int c = 0; c < NCH; c++) begin
                s1_pil_reg[c]  <= PW'(in_base[c]) * PW'(in_top[c]);
                s1_pnil_reg[c] <= PW'(FULL - in_base[c]) * PW'(FULL - in_top[c]);
            end
        end
    end

    // stage 2: round products
    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_base_reg <= s1_base_reg;
            s2_ba_reg   <= s1_ba_reg;
            s2_mk_reg   <= s1_mk_reg;
            s2_re_reg   <= s1_re_reg;
            s2_ca0_reg  <= rnd_full(RW'(s1_pca_reg));
            for (int c = 0; c < NCH; c++) begin
                s2_mul_reg[c] <= rnd_full(RW'(s1_pil_reg[c]));
                s2_scr_reg[c] <= FULL - rnd_full(RW'(s1_pnil_reg[c]));
            end
        end
    end

    // stage 3: mask product and soft-light terms
    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_base_reg <= s2_base_reg;
            s3_ba_reg   <= s2_ba_reg;
            s3_re_reg   <= s2_re_reg;
            s3_ca0_reg  <= s2_ca0_reg;
            s3_pmk_reg  <= PW'(s2_ca0_reg) * PW'(s2_mk_reg);
            for (int c = 0; c < NCH; c++) begin
                s3_pa_reg[c] <= PW'(FULL - s2_base_reg[c]) * PW'(s2_mul_reg[c]);
                s3_pb_reg[c] <= PW'(s2_base_reg[c]) * PW'(s2_scr_reg[c]);
            end
        end
    end

    // stage 4: compositing alpha and soft-light colour
    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_base_reg <= s3_base_reg;
            s4_ba_reg   <= s3_ba_reg;
            s4_re_reg   <= s3_re_reg;
            s4_ca_reg   <= mask_en_reg ? rnd_full(RW'(s3_pmk_reg)) : s3_ca0_reg;
            for (int c = 0; c < NCH; c++) begin
                s4_comp_reg[c] <= rnd_full(RW'(s3_pa_reg[c]) + RW'(s3_pb_reg[c]));
            end
        end
    end

    // stage 5: alpha coverage product
    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_base_reg <= s4_base_reg;
            s5_ba_reg   <= s4_ba_reg;
            s5_re_reg   <= s4_re_reg;
            s5_ca_reg   <= s4_ca_reg;
            s5_comp_reg <= s4_comp_reg;
            s5_pna_reg  <= PW'(FULL - s4_ba_reg) * PW'(s4_ca_reg);
        end
    end

    // stage 6: new alpha, signed difference as sign and magnitude
    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_base_reg <= s5_base_reg;
            s6_ba_reg   <= s5_ba_reg;
            s6_re_reg   <= s5_re_reg;
            s6_ca_reg   <= s5_ca_reg;
            s6_na_reg   <= s5_ba_reg + rnd_full(RW'(s5_pna_reg));
            for (int c = 0; c < NCH; c++) begin
                s6_neg_reg[c] <= s5_comp_reg[c] < s5_base_reg[c];
                s6_mag_reg[c] <= (s5_comp_reg[c] < s5_base_reg[c])
                                 ? s5_base_reg[c] - s5_comp_reg[c]
                                 : s5_comp_reg[c] - s5_base_reg[c];
            end
        end
    end

    // stage 7: difference times compositing alpha
    always_ff @(posedge aclk) begin
        if (adv) begin
            s7_base_reg <= s6_base_reg;
            s7_ba_reg   <= s6_ba_reg;
            s7_re_reg   <= s6_re_reg;
            s7_na_reg   <= s6_na_reg;
            s7_neg_reg  <= s6_neg_reg;
            s7_pass_reg <= (s6_ca_reg == '0) || (s6_na_reg == '0);
            for (int c = 0; c < NCH; c++) begin
                s7_pmc_reg[c] <= PW'(s6_mag_reg[c]) * PW'(s6_ca_reg);
            end
        end
    end

    // stage 8: rounded-division operands
    always_ff @(posedge aclk) begin
        if (adv) begin
            den_reg             <= {s7_na_reg, 1'b0};
            s8_side_reg.base    <= s7_base_reg;
            s8_side_reg.neg     <= s7_neg_reg;
            s8_side_reg.pass    <= s7_pass_reg;
            s8_side_reg.alpha   <= s7_ba_reg;
            s8_side_reg.run_end <= s7_re_reg;
            for (int c = 0; c < NCH; c++) begin
                num_reg[c] <= (RW'(s7_pmc_reg[c]) << 1) + RW'(s7_na_reg);
            end
        end
    end

    for (genvar g = 0; g < NCH; g++) begin : g_div
        slb_div u_div (
            .aclk    (aclk),
            .en      (adv),
            .num_in  (num_reg[g]),
            .den_in  (den_reg),
            .quo_out (quo[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= s8_side_reg;
            for (int k = 1; k < QW; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // apply the ratio and saturate
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            sum_w[c] = (CW+2)'(side_reg[QW-1].base[c]) + (CW+2)'(quo[c]);
            if (side_reg[QW-1].pass) begin
                res[c] = side_reg[QW-1].base[c];
            end else if (side_reg[QW-1].neg[c]) begin
                if ((CW+2)'(quo[c]) > (CW+2)'(side_reg[QW-1].base[c])) begin
                    res[c] = '0;
                end else begin
                    res[c] = side_reg[QW-1].base[c] - quo[c][CW-1:0];
                end
            end else begin
                if (sum_w[c] > (CW+2)'(FULL)) begin
                    res[c] = FULL;
                end else begin
                    res[c] = sum_w[c][CW-1:0];
                end
            end
        end
        item.red     = FIELD_W'(res[0]);
        item.green   = FIELD_W'(res[1]);
        item.blue    = FIELD_W'(res[2]);
        item.alpha   = FIELD_W'(side_reg[QW-1].alpha);
        item.run_end = side_reg[QW-1].run_end;
    end

    // output skid buffer
    always_comb begin
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= item;
        end
    end

    assign m_valid          = cnt_reg != 2'd0;
    assign m_result_red     = fifo_reg[rd_ptr_reg].red;
    assign m_result_green   = fifo_reg[rd_ptr_reg].green;
    assign m_result_blue    = fifo_reg[rd_ptr_reg].blue;
    assign m_result_alpha   = fifo_reg[rd_ptr_reg].alpha;
    assign m_result_run_end = fifo_reg[rd_ptr_reg].run_end;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && cnt_reg == 2'd2) |-> pop)
        else $error("item pushed into a full output buffer");

    a_stall_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2 && v_reg[NV-1] && !m_ready) |-> !s_ready)
        else $error("input taken while the pipeline is stalled");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> (cnt_reg == $past(cnt_reg) - 2'd1))
        else $error("output buffer count lost track of a delivered item");

endmodule

FILE: rtl/slb_div.sv
// Pipelined restoring divider, one quotient bit per stage, for the blend ratio.
// Depends on slb_pkg for widths.
module slb_div import slb_pkg::*; (
    input  logic          aclk,
    input  logic          en,
    input  logic [RW-1:0] num_in,
    input  logic [DW-1:0] den_in,
    output logic [QW-1:0] quo_out
);

    logic [RW-1:0] rem_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [RW-1:0] rem_in   [QW];
    logic [DW-1:0] den_s    [QW];
    logic [QW-1:0] quo_in   [QW];
    logic [RW-1:0] sub      [QW];
    logic [RW-1:0] rem_next [QW];
    logic [QW-1:0] quo_next [QW];
    logic [QW-1:0] ge;

    always_comb begin
        rem_in[0] = num_in;
        den_s[0]  = den_in;
        quo_in[0] = '0;
        for (int s = 1; s < QW; s++) begin
            rem_in[s] = rem_reg[s-1];
            den_s[s]  = den_reg[s-1];
            quo_in[s] = quo_reg[s-1];
        end
        for (int s = 0; s < QW; s++) begin
            sub[s]      = RW'(den_s[s]) << (QW - 1 - s);
            ge[s]       = rem_in[s] >= sub[s];
            rem_next[s] = ge[s] ? rem_in[s] - sub[s] : rem_in[s];
            quo_next[s] = quo_in[s] | (QW'(ge[s]) << (QW - 1 - s));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < QW; s++) begin
                rem_reg[s] <= rem_next[s];
                den_reg[s] <= den_s[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    assign quo_out = quo_reg[QW-1];

endmodule

FILE: dv/slb_blend_checker.sv
// Checker for soft_light_layer_blend: watches the register, pixel and result channels,
// predicts each blended pixel in 64-bit integer arithmetic and compares it in order.
// Depends on slb_pkg for widths, register indexes and the result item type.
module slb_blend_checker import slb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [FIELD_W-1:0]   s_base_red,
    input  logic [FIELD_W-1:0]   s_base_green,
    input  logic [FIELD_W-1:0]   s_base_blue,
    input  logic [FIELD_W-1:0]   s_base_alpha,
    input  logic [FIELD_W-1:0]   s_top_red,
    input  logic [FIELD_W-1:0]   s_top_green,
    input  logic [FIELD_W-1:0]   s_top_blue,
    input  logic [FIELD_W-1:0]   s_top_alpha,
    input  logic [FIELD_W-1:0]   s_mask_value,
    input  logic                 s_run_end,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [FIELD_W-1:0]   m_result_red,
    input  logic [FIELD_W-1:0]   m_result_green,
    input  logic [FIELD_W-1:0]   m_result_blue,
    input  logic [FIELD_W-1:0]   m_result_alpha,
    input  logic                 m_result_run_end,
    output int                   fail_count,
    output int                   results_seen
);

    localparam longint unsigned UNITY = 64'(FULL);

    logic [FIELD_W-1:0] opacity_q;
    logic               mask_on_q;
    out_item_t          expected_pixels[$];

    function automatic longint unsigned to_chan(input logic [FIELD_W-1:0] v);
        longint unsigned w;
        w = 64'(v);
        return (w > UNITY) ? UNITY : w;
    endfunction

    function automatic longint unsigned scale_round(input longint unsigned x);
        return (2 * x + UNITY) / (2 * UNITY);
    endfunction

    function automatic chan_t blend_lane(input longint unsigned i, input longint unsigned l,
                                         input longint unsigned ca, input longint unsigned na);
        longint unsigned mul;
        longint unsigned scr;
        longint unsigned comp;
        longint unsigned mag;
        longint unsigned q;
        longint          res;
        mul  = scale_round(i * l);
        scr  = UNITY - scale_round((UNITY - i) * (UNITY - l));
        comp = scale_round((UNITY - i) * mul + i * scr);
        mag  = (comp < i) ? (i - comp) : (comp - i);
        // ratio applied to the signed difference, rounded half away from zero
        q    = (2 * mag * ca + na) / (2 * na);
        res  = (comp < i) ? (longint'(i) - longint'(q)) : longint'(i + q);
        if (res < 0) begin
            res = 0;
        end else if (res > longint'(UNITY)) begin
            res = longint'(UNITY);
        end
        return chan_t'(res);
    endfunction

    function automatic out_item_t soft_light_predict(
        input logic [FIELD_W-1:0] br, input logic [FIELD_W-1:0] bg,
        input logic [FIELD_W-1:0] bb, input logic [FIELD_W-1:0] ba,
        input logic [FIELD_W-1:0] tr, input logic [FIELD_W-1:0] tg,
        input logic [FIELD_W-1:0] tb, input logic [FIELD_W-1:0] ta,
        input logic [FIELD_W-1:0] mv, input logic last
    );
        longint unsigned base_a;
        longint unsigned lower_a;
        longint unsigned ca;
        longint unsigned na;
        out_item_t       px;
        base_a  = to_chan(ba);
        lower_a = (base_a < to_chan(ta)) ? base_a : to_chan(ta);
        ca = scale_round(lower_a * to_chan(opacity_q));
        if (mask_on_q) begin
            ca = scale_round(ca * to_chan(mv));
        end
        na = base_a + scale_round((UNITY - base_a) * ca);
        if (ca != 0 && na != 0) begin
            px.red   = FIELD_W'(blend_lane(to_chan(br), to_chan(tr), ca, na));
            px.green = FIELD_W'(blend_lane(to_chan(bg), to_chan(tg), ca, na));
            px.blue  = FIELD_W'(blend_lane(to_chan(bb), to_chan(tb), ca, na));
        end else begin
            px.red   = FIELD_W'(to_chan(br));
            px.green = FIELD_W'(to_chan(bg));
            px.blue  = FIELD_W'(to_chan(bb));
        end
        px.alpha   = FIELD_W'(base_a);
        px.run_end = last;
        return px;
    endfunction

    always @(posedge aclk) begin : watch
        out_item_t want;
        logic      bad;
        if (!aresetn) begin
            opacity_q    <= FIELD_W'(FULL);
            mask_on_q    <= 1'b0;
            expected_pixels.delete();
            fail_count   <= 0;
            results_seen <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_pixels.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("unexpected result r=%h g=%h b=%h a=%h end=%b",
                                 m_result_red, m_result_green, m_result_blue,
                                 m_result_alpha, m_result_run_end);
                    end
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_pixels.pop_front();
                    bad  = (want.red != m_result_red) || (want.green != m_result_green) ||
                           (want.blue != m_result_blue) || (want.alpha != m_result_alpha) ||
                           (want.run_end != m_result_run_end);
                    if (bad) begin
                        if (fail_count < 10) begin
                            $display("mismatch: expected r=%h g=%h b=%h a=%h end=%b",
                                     want.red, want.green, want.blue, want.alpha,
                                     want.run_end);
                            $display("          got      r=%h g=%h b=%h a=%h end=%b",
                                     m_result_red, m_result_green, m_result_blue,
                                     m_result_alpha, m_result_run_end);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_pixels.push_back(soft_light_predict(
                    s_base_red, s_base_green, s_base_blue, s_base_alpha,
                    s_top_red, s_top_green, s_top_blue, s_top_alpha,
                    s_mask_value, s_run_end));
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_OPACITY: begin
                        opacity_q <= cfg_data;
                    end
                    REG_MASK_ENABLE: begin
                        mask_on_q <= cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

FILE: dv/tb_top.sv
// Testbench top for soft_light_layer_blend: clock, reset, register writes, pixel stimulus
// and result back-pressure; the verdict uses the checker's failure and result counts.
// Depends on slb_pkg, soft_light_layer_blend and slb_blend_checker.
module tb_top import slb_pkg::*; ();

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(9);

    typedef struct packed {
        logic [FIELD_W-1:0] br;
        logic [FIELD_W-1:0] bg;
        logic [FIELD_W-1:0] bb;
        logic [FIELD_W-1:0] ba;
        logic [FIELD_W-1:0] tr;
        logic [FIELD_W-1:0] tg;
        logic [FIELD_W-1:0] tb;
        logic [FIELD_W-1:0] ta;
        logic [FIELD_W-1:0] mv;
        logic               last;
    } pixel_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FIELD_W-1:0]   cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [FIELD_W-1:0]   s_base_red = '0;
    logic [FIELD_W-1:0]   s_base_green = '0;
    logic [FIELD_W-1:0]   s_base_blue = '0;
    logic [FIELD_W-1:0]   s_base_alpha = '0;
    logic [FIELD_W-1:0]   s_top_red = '0;
    logic [FIELD_W-1:0]   s_top_green = '0;
    logic [FIELD_W-1:0]   s_top_blue = '0;
    logic [FIELD_W-1:0]   s_top_alpha = '0;
    logic [FIELD_W-1:0]   s_mask_value = '0;
    logic                 s_run_end = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [FIELD_W-1:0]   m_result_red;
    logic [FIELD_W-1:0]   m_result_green;
    logic [FIELD_W-1:0]   m_result_blue;
    logic [FIELD_W-1:0]   m_result_alpha;
    logic                 m_result_run_end;
    int                   fail_count;
    int                   results_seen;

    int send_idle = 21;
    int recv_idle = 79;
    int items_sent = 0;

    soft_light_layer_blend dut (.*);

    slb_blend_checker checker_i (.*);

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input logic [FIELD_W-1:0] opac,
                                  input logic [FIELD_W-1:0] mask_word);
        write_reg(REG_OPACITY, opac);
        write_reg(REG_MASK_ENABLE, mask_word);
        write_reg(REG_SPARE, FIELD_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input pixel_t p);
        if ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle);
        end
        s_valid        <= 1'b1;
        s_base_red     <= p.br;
        s_base_green   <= p.bg;
        s_base_blue    <= p.bb;
        s_base_alpha   <= p.ba;
        s_top_red      <= p.tr;
        s_top_green    <= p.tg;
        s_top_blue     <= p.tb;
        s_top_alpha    <= p.ta;
        s_mask_value   <= p.mv;
        s_run_end      <= p.last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // hold off until every pixel sent has come back
    task automatic drain();
        s_valid <= 1'b0;
        while (results_seen < items_sent) @(posedge aclk);
    endtask

    function automatic logic [FIELD_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return FULL;
            2: return FIELD_W'($urandom_range(0, 3));
            3: return FULL - FIELD_W'($urandom_range(0, 3));
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        p.br   = pick_level();
        p.bg   = pick_level();
        p.bb   = pick_level();
        p.ba   = pick_level();
        p.tr   = pick_level();
        p.tg   = pick_level();
        p.tb   = pick_level();
        p.ta   = pick_level();
        p.mv   = pick_level();
        p.last = ($urandom_range(0, 7) == 0);
        return p;
    endfunction

    initial begin
        logic [FIELD_W-1:0] opac;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: full opacity, mask off
        send_pixel({16'h0000, 16'h0000, 16'h0000, 16'h0000,
                    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0});
        send_pixel({FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL, 1'b1});
        send_pixel({FULL, 16'h0000, 16'h8000, FULL,
                    16'h0000, FULL, 16'h8000, FULL, 16'h0000, 1'b0});
        send_pixel({16'hC000, 16'h4000, 16'h1234, 16'h0000,
                    16'h0000, FULL, 16'hABCD, FULL, 16'h0000, 1'b0});
        send_pixel({16'hC000, 16'h4000, 16'h1234, FULL,
                    16'h0000, FULL, 16'hABCD, 16'h0000, FULL, 1'b1});
        send_pixel({16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                    16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hAAAA, 1'b0});
        send_pixel({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                    16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'h5555, 1'b1});
        send_pixel({16'h0001, 16'hFFFE, 16'h8000, 16'h0001,
                    16'hFFFE, 16'h0001, 16'h7FFF, FULL, 16'h0000, 1'b0});
        send_pixel({FULL, 16'h0000, 16'hC000, 16'h8000,
                    16'h0000, FULL, 16'h0000, 16'h8000, 16'h1234, 1'b0});
        drain();

        apply_settings(FULL, 16'h0001);
        send_pixel({16'h8000, 16'h4000, 16'hC000, FULL,
                    16'h2000, 16'hE000, 16'h0000, FULL, 16'h0000, 1'b0});
        send_pixel({16'h8000, 16'h4000, 16'hC000, FULL,
                    16'h2000, 16'hE000, 16'h0000, FULL, FULL, 1'b1});
        send_pixel({16'h3000, 16'hD000, 16'h0001, FULL,
                    FULL, 16'h0000, FULL, FULL, 16'h0001, 1'b0});
        send_pixel({16'h3000, 16'hD000, 16'hFFFE, 16'h8000,
                    16'h9000, 16'h1000, 16'h0002, 16'hC000, 16'h8000, 1'b1});
        drain();

        // only bit 0 of the mask word counts
        apply_settings(16'h0000, 16'hFFFE);
        send_pixel({16'h1111, 16'h9999, 16'hEEEE, FULL,
                    16'h7777, 16'h2222, 16'hCCCC, FULL, FULL, 1'b0});
        send_pixel({16'h4321, 16'h8765, 16'hFEDC, 16'h0100,
                    16'hBA98, 16'h7654, 16'h3210, 16'h0F00, 16'h00FF, 1'b1});
        drain();

        apply_settings(16'h0001, 16'h0001);
        send_pixel({16'h2000, 16'hF000, 16'h8000, FULL,
                    16'hF000, 16'h1000, 16'h0000, FULL, FULL, 1'b0});
        send_pixel({16'h2000, 16'hF000, 16'h8000, 16'h0001,
                    16'hF000, 16'h1000, 16'h0000, FULL, FULL, 1'b0});
        send_pixel({16'h2000, 16'hF000, 16'h8000, 16'h0000,
                    16'hF000, 16'h1000, 16'h0000, 16'h0000, FULL, 1'b1});
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle = 21;
                    recv_idle = 79;
                end
                1: begin
                    send_idle = 79;
                    recv_idle = 21;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (int seg = 0; seg < 4; seg++) begin
                case (seg)
                    0: opac = FULL;
                    1: opac = FIELD_W'($urandom);
                    2: opac = FIELD_W'($urandom_range(0, 255));
                    default: opac = FULL - FIELD_W'($urandom_range(0, 255));
                endcase
                apply_settings(opac, (FIELD_W'($urandom) & 16'hFFFE) | FIELD_W'(seg % 2));
                repeat (142) send_pixel(random_pixel());
                drain();
            end
        end

        repeat (40) @(posedge aclk);
        if (fail_count == 0 && results_seen == items_sent) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(200_000 * 20);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
